// File: rtl/core/idxh_pkg.sv
// Shared types and constants for the indexed min-heap.
`timescale 1ns / 1ps
package idxh_pkg;

  localparam int DefaultCapacity = 1024;
  localparam int VertexW = 10;
  localparam int NumVertices = 1 << VertexW;
  localparam int KeyW = 32;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_DECREASE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STATUS_OK      = 3'd0,
    STATUS_FULL    = 3'd1,
    STATUS_EMPTY   = 3'd2,
    STATUS_ABSENT  = 3'd3,
    STATUS_PRESENT = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_LAST,
    S_UP,
    S_UP_CMP,
    S_DOWN,
    S_DOWN_CMP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [VertexW-1:0] vertex;
  } entry_t;

endpackage

// File: rtl/core/indexed_min_heap_decrease_key.sv
// Top level of the indexed binary min-heap with insert, extract-min and decrease-key.
`timescale 1ns / 1ps
// One request at a time. After reset a clearing pass marks every vertex absent
// before the first request is taken. A request is captured in S_IDLE and checked
// in S_CHECK, then a sift-up alternates S_UP and S_UP_CMP for each level climbed
// and an extract fetches the last entry in S_LAST and alternates S_DOWN and
// S_DOWN_CMP for each level descended, bounded by log2(CAPACITY) levels; S_RESP
// hands the response to the output register once that register is free. The pace
// is set by the slot memory, which is read and written once per level step.
module indexed_min_heap_decrease_key import idxh_pkg::*; #(
  parameter int CAPACITY = DefaultCapacity,
  parameter int SlotW = $clog2(CAPACITY),
  parameter int CountW = $clog2(CAPACITY + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [VertexW-1:0] vertex_id_i,
  input  logic [KeyW-1:0]    key_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [VertexW-1:0] out_vertex_o,
  output logic [KeyW-1:0]    out_key_o,
  output logic [2:0]         status_o,
  output logic               is_empty_o,
  output logic [CountW-1:0]  entry_count_o
);

  state_e state_q, state_d;
  logic [VertexW-1:0] clr_q, clr_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [SlotW-1:0] idx_q, idx_d;
  entry_t e_q, e_d;
  op_e op_q, op_d;
  logic [VertexW-1:0] vtx_q, vtx_d;
  logic [KeyW-1:0] key_q, key_d;
  entry_t res_q, res_d;
  status_e status_q, status_d;
  logic out_valid_q;
  logic [VertexW-1:0] out_vertex_q;
  logic [KeyW-1:0] out_key_q;
  logic [2:0] out_status_q;
  logic [CountW-1:0] out_count_q;

  logic ram_we;
  logic [SlotW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  entry_t ram_wdata, rd_a, rd_b;

  logic [SlotW:0] pos_mem [NumVertices];
  logic [SlotW:0] pos_rd_q;
  logic pos_we;
  logic [VertexW-1:0] pos_waddr;
  logic [SlotW:0] pos_wdata;

  logic [SlotW+1:0] left_w, right_w, cnt_w;
  logic left_ok, right_ok;
  logic [SlotW-1:0] parent_idx, last_idx;
  entry_t child;
  logic [SlotW-1:0] child_idx;
  logic down_swap, up_swap, out_free;

  idxh_slot_ram #(
    .Depth (CAPACITY),
    .AddrW (SlotW)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rd_q <= pos_mem[vertex_id_i];
  end

  assign cnt_w = (SlotW + 2)'(cnt_q);
  assign left_w = {1'b0, idx_q, 1'b1};
  assign right_w = {1'b0, idx_q, 1'b0} + (SlotW + 2)'(2);
  assign left_ok = left_w < cnt_w;
  assign right_ok = right_w < cnt_w;
  assign parent_idx = (idx_q - SlotW'(1)) >> 1;
  assign last_idx = SlotW'(cnt_q - CountW'(1));
  assign up_swap = rd_a.key > e_q.key;
  assign child = (right_ok && (rd_b.key < rd_a.key)) ? rd_b : rd_a;
  assign child_idx = (right_ok && (rd_b.key < rd_a.key)) ? right_w[SlotW-1:0]
                                                          : left_w[SlotW-1:0];
  assign down_swap = child.key < e_q.key;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == {VertexW{1'b1}}) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        unique case (op_q)
          OP_INSERT: begin
            if (pos_rd_q[SlotW] || cnt_q == CountW'(CAPACITY)) state_d = S_RESP;
            else state_d = S_UP;
          end
          OP_EXTRACT: begin
            if (cnt_q <= CountW'(1)) state_d = S_RESP;
            else state_d = S_LAST;
          end
          OP_DECREASE: begin
            if (!pos_rd_q[SlotW] || CountW'(pos_rd_q[SlotW-1:0]) >= cnt_q) state_d = S_RESP;
            else state_d = S_UP;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_LAST: state_d = S_DOWN;
      S_UP: begin
        if (idx_q == '0) state_d = S_RESP;
        else state_d = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (up_swap) state_d = S_UP;
        else state_d = S_RESP;
      end
      S_DOWN: begin
        if (left_ok) state_d = S_DOWN_CMP;
        else state_d = S_RESP;
      end
      S_DOWN_CMP: begin
        if (down_swap) state_d = S_DOWN;
        else state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    clr_d = clr_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    e_d = e_q;
    op_d = op_q;
    vtx_d = vtx_q;
    key_d = key_q;
    res_d = res_q;
    status_d = status_q;
    ram_we = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = e_q;
    ram_raddr_a = '0;
    ram_raddr_b = '0;
    pos_we = 1'b0;
    pos_waddr = e_q.vertex;
    pos_wdata = {1'b1, idx_q};
    unique case (state_q)
      S_CLEAR: begin
        pos_we = 1'b1;
        pos_waddr = clr_q;
        pos_wdata = '0;
        clr_d = clr_q + VertexW'(1);
      end
      S_IDLE: begin
        op_d = op_e'(operation_i);
        vtx_d = vertex_id_i;
        key_d = key_value_i;
        res_d = '0;
        status_d = STATUS_OK;
      end
      S_CHECK: begin
        ram_raddr_a = last_idx;
        unique case (op_q)
          OP_INSERT: begin
            if (pos_rd_q[SlotW]) begin
              status_d = STATUS_PRESENT;
            end else if (cnt_q == CountW'(CAPACITY)) begin
              status_d = STATUS_FULL;
            end else begin
              idx_d = cnt_q[SlotW-1:0];
              cnt_d = cnt_q + CountW'(1);
              e_d = '{key: key_q, vertex: vtx_q};
            end
          end
          OP_EXTRACT: begin
            if (cnt_q == '0) begin
              status_d = STATUS_EMPTY;
            end else begin
              res_d = rd_a;
              cnt_d = cnt_q - CountW'(1);
              idx_d = '0;
              pos_we = 1'b1;
              pos_waddr = rd_a.vertex;
              pos_wdata = '0;
            end
          end
          OP_DECREASE: begin
            if (!pos_rd_q[SlotW] || CountW'(pos_rd_q[SlotW-1:0]) >= cnt_q) begin
              status_d = STATUS_ABSENT;
            end else begin
              idx_d = pos_rd_q[SlotW-1:0];
              e_d = '{key: key_q, vertex: vtx_q};
            end
          end
          default: status_d = STATUS_OK;
        endcase
      end
      S_LAST: begin
        e_d = rd_a;
      end
      S_UP: begin
        ram_raddr_a = parent_idx;
        if (idx_q == '0) begin
          ram_we = 1'b1;
          pos_we = 1'b1;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        pos_we = 1'b1;
        if (up_swap) begin
          ram_wdata = rd_a;
          pos_waddr = rd_a.vertex;
          idx_d = parent_idx;
        end
      end
      S_DOWN: begin
        ram_raddr_a = left_w[SlotW-1:0];
        ram_raddr_b = right_w[SlotW-1:0];
        if (!left_ok) begin
          ram_we = 1'b1;
          pos_we = 1'b1;
        end
      end
      S_DOWN_CMP: begin
        ram_we = 1'b1;
        pos_we = 1'b1;
        if (down_swap) begin
          ram_wdata = child;
          pos_waddr = child.vertex;
          idx_d = child_idx;
        end
      end
      S_RESP: begin
        ram_we = 1'b0;
      end
      default: clr_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      cnt_q <= cnt_d;
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    e_q <= e_d;
    op_q <= op_d;
    vtx_q <= vtx_d;
    key_q <= key_d;
    res_q <= res_d;
    status_q <= status_d;
    if (state_q == S_RESP && out_free) begin
      out_vertex_q <= res_q.vertex;
      out_key_q <= res_q.key;
      out_status_q <= status_q;
      out_count_q <= cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_vertex_o = out_vertex_q;
  assign out_key_o = out_key_q;
  assign status_o = out_status_q;
  assign entry_count_o = out_count_q;
  assign is_empty_o = (out_count_q == '0);

endmodule

// File: rtl/core/idxh_slot_ram.sv
// Heap slot memory with one write port and two registered read ports.
`timescale 1ns / 1ps
module idxh_slot_ram import idxh_pkg::*; #(
  parameter int Depth = DefaultCapacity,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output entry_t           rdata_a_o,
  output entry_t           rdata_b_o
);

  entry_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule
